// ===== design/psa_pkg.sv =====
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types, constants and control structs for the paged slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int unsigned PageSlots  = 32;
  localparam int unsigned PageCount  = 16;
  localparam int unsigned MaxSpawns  = 64;
  localparam int unsigned PageW      = 4;
  localparam int unsigned SlotW      = 5;
  localparam int unsigned LenW       = 5;
  localparam int unsigned LiveW      = 10;
  localparam int unsigned AgeAw      = PageW + SlotW;

  localparam logic [1:0] RegMaxLife  = 2'd0;
  localparam logic [1:0] RegInterval = 2'd1;
  localparam logic [1:0] RegPages    = 2'd2;

  localparam logic ReqTick  = 1'b0;
  localparam logic ReqSpawn = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [15:0] elapsed;
    logic [6:0]  spawn_count;
  } in_item_t;

  typedef struct packed {
    logic             placed;
    logic [PageW-1:0] page_number;
    logic [SlotW-1:0] slot_number;
    logic [LiveW-1:0] live_count;
    logic             last;
  } out_item_t;

  typedef enum logic [3:0] {
    StIdle,
    StAgeLoad,
    StAgeRead,
    StAgeSlot,
    StAgeEnd,
    StRetire,
    StAccum,
    StPlace,
    StPlaceRes,
    StEmit,
    StEmpty
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic age_page_load;
    logic age_read;
    logic age_slot;
    logic age_page_end;
    logic retire_step;
    logic accum;
    logic place_start;
    logic place_commit;
    logic emit_place;
    logic emit_empty;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic age_pages_done;
    logic age_slot_last;
    logic retire_done;
    logic tick_can_place;
    logic spawn_more;
    logic place_found;
    logic any_emitted;
  } stat_t;

endpackage

// ===== design/psa_ctrl.sv =====
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer: for a tick, age sweep, page retirement, accumulate, then placements; a spawn goes straight to placements.
// ----------------------------------------------------------------------------
module psa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  input  psa_pkg::stat_t   stat_i,
  output psa_pkg::ctrl_t   ctrl_o
);
  import psa_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:     if (in_valid_i) state_d = StAgeLoad;
      StAgeLoad:  begin
        if (!stat_i.is_tick) state_d = StPlace;
        else if (stat_i.age_pages_done) state_d = StRetire;
        else state_d = StAgeRead;
      end
      StAgeRead:  state_d = StAgeSlot;
      StAgeSlot:  if (stat_i.age_slot_last) state_d = StAgeEnd;
                  else state_d = StAgeRead;
      StAgeEnd:   state_d = StAgeLoad;
      StRetire:   if (stat_i.retire_done) state_d = StAccum;
      StAccum:    state_d = StPlace;
      StPlace:    begin
        if (stat_i.is_tick ? stat_i.tick_can_place : stat_i.spawn_more)
          state_d = StPlaceRes;
        else if (stat_i.any_emitted) state_d = StIdle;
        else state_d = StEmpty;
      end
      StPlaceRes: begin
        if (stat_i.place_found) state_d = StEmit;
        else if (stat_i.is_tick) state_d = stat_i.any_emitted ? StIdle : StEmpty;
        else state_d = StPlace;
      end
      StEmit:     if (out_free) state_d = StPlace;
      StEmpty:    if (out_free) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl_o      = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      StIdle:     ctrl_o.load_item     = in_valid_i;
      StAgeLoad:  ctrl_o.age_page_load = stat_i.is_tick && !stat_i.age_pages_done;
      StAgeRead:  ctrl_o.age_read      = 1'b1;
      StAgeSlot:  ctrl_o.age_slot      = 1'b1;
      StAgeEnd:   ctrl_o.age_page_end  = 1'b1;
      StRetire:   ctrl_o.retire_step   = 1'b1;
      StAccum:    ctrl_o.accum         = 1'b1;
      StPlace:    ctrl_o.place_start   =
                    stat_i.is_tick ? stat_i.tick_can_place : stat_i.spawn_more;
      StPlaceRes: ctrl_o.place_commit  = stat_i.place_found;
      StEmit:     begin
        ctrl_o.emit_place = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      StEmpty:    begin
        ctrl_o.emit_empty = out_free;
        if (out_free) out_valid_d = 1'b1;
      end
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== design/psa_datapath.sv =====
// ----------------------------------------------------------------------------
// psa_datapath
// Bitmaps, age memory, active list, counters and the result register.
// ----------------------------------------------------------------------------
module psa_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psa_pkg::in_item_t   in_item_i,
  input  logic [31:0]         max_life_i,
  input  logic [31:0]         interval_i,
  input  logic [4:0]          pages_i,
  input  psa_pkg::ctrl_t      ctrl_i,
  output psa_pkg::stat_t      stat_o,
  output psa_pkg::out_item_t  out_item_o
);
  import psa_pkg::*;

  logic [PageSlots-1:0] occ_q [PageCount];
  logic [PageW-1:0]     act_q [PageCount];
  logic [31:0]          age_mem [PageCount*PageSlots];
  logic [31:0]          age_rd_q;

  logic [LenW-1:0]  act_len_q;
  logic [LiveW-1:0] live_q;
  logic [31:0]      acc_q;
  logic             is_tick_q;
  logic [15:0]      delta_q;
  logic [6:0]       count_q;
  logic [6:0]       n_q;
  logic [LenW-1:0]  idx_q;
  logic [PageW-1:0] cur_page_q;
  logic [SlotW-1:0] slot_q;
  logic [PageW-1:0] emp_q [PageCount];
  logic [LenW-1:0]  emp_cnt_q;
  logic [LenW-1:0]  emp_rd_q;
  logic             found_q;
  logic [PageW-1:0] fpage_q;
  logic [SlotW-1:0] fslot_q;
  logic             fnew_q;
  logic             out_placed_q;
  logic [PageW-1:0] out_page_q;
  logic [SlotW-1:0] out_slot_q;
  logic [LiveW-1:0] out_live_q;
  logic             out_last_q;

  logic [4:0]  lim;
  logic [31:0] interval;
  logic [LiveW-1:0] cap;
  logic [32:0] age_sum;
  logic [31:0] age_new;
  logic [32:0] acc_sum;
  logic        cur_bit;

  assign lim      = (pages_i > 5'(PageCount)) ? 5'(PageCount) : pages_i;
  assign interval = (interval_i == '0) ? 32'd1 : interval_i;
  assign cap      = LiveW'(lim) << SlotW;
  assign age_sum  = {1'b0, age_rd_q} + {17'd0, delta_q};
  assign age_new  = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
  assign acc_sum  = {1'b0, acc_q} + {17'd0, delta_q};
  assign cur_bit  = occ_q[cur_page_q][slot_q];

  // Placement search over the active list, then the empty pages
  logic             s_found, s_new;
  logic [PageW-1:0] s_page;
  logic [SlotW-1:0] s_slot;
  logic             s_done;
  always_comb begin
    logic [PageW-1:0] p;
    s_found = 1'b0;
    s_new   = 1'b0;
    s_page  = '0;
    s_slot  = '0;
    s_done  = 1'b0;
    for (int i = 0; i < PageCount; i++) begin
      p = act_q[i];
      if (!s_done && (LenW'(i) < act_len_q) && ({1'b0, p} < lim) && (~occ_q[p] != '0)) begin
        s_done  = 1'b1;
        s_found = 1'b1;
        s_page  = p;
        for (int s = PageSlots - 1; s >= 0; s--)
          if (!occ_q[p][s]) s_slot = SlotW'(s);
      end
    end
    for (int q = 0; q < PageCount; q++) begin
      if (!s_done && (5'(q) < lim) && (occ_q[q] == '0)) begin
        s_done = 1'b1;
        if (act_len_q < LenW'(PageCount)) begin
          s_found = 1'b1;
          s_new   = 1'b1;
          s_page  = PageW'(q);
          s_slot  = '0;
        end
      end
    end
  end

  // Retire: remove emptied pages in the order the sweep found them
  logic             r_hit;
  logic [PageW-1:0] r_page;
  logic [PageW-1:0] r_idx;
  always_comb begin
    r_hit  = (emp_rd_q < emp_cnt_q);
    r_page = emp_q[emp_rd_q[PageW-1:0]];
    r_idx  = '0;
    for (int i = PageCount - 1; i >= 0; i--)
      if ((LenW'(i) < act_len_q) && (act_q[i] == r_page)) r_idx = PageW'(i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.age_read) age_rd_q <= age_mem[{cur_page_q, slot_q}];
    if (ctrl_i.age_slot && cur_bit) age_mem[{cur_page_q, slot_q}] <= age_new;
    else if (ctrl_i.place_commit) age_mem[{fpage_q, fslot_q}] <= '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PageCount; i++) occ_q[i] <= '0;
      act_len_q    <= '0;
      live_q       <= '0;
      acc_q        <= '0;
      is_tick_q    <= 1'b0;
      idx_q        <= '0;
      slot_q       <= '0;
      emp_cnt_q    <= '0;
      emp_rd_q     <= '0;
      found_q      <= 1'b0;
      n_q          <= '0;
    end else begin
      if (ctrl_i.load_item) begin
        is_tick_q <= (in_item_i.req_type == ReqTick);
        delta_q   <= in_item_i.elapsed;
        count_q   <= (in_item_i.spawn_count > 7'(MaxSpawns)) ? 7'(MaxSpawns)
                                                             : in_item_i.spawn_count;
        n_q       <= '0;
        idx_q     <= '0;
        emp_cnt_q <= '0;
        emp_rd_q  <= '0;
      end
      if (ctrl_i.age_page_load) begin
        cur_page_q <= act_q[idx_q[PageW-1:0]];
        slot_q     <= '0;
      end
      if (ctrl_i.age_slot) begin
        if (cur_bit && (age_new >= max_life_i)) begin
          occ_q[cur_page_q][slot_q] <= 1'b0;
          if (live_q != '0) live_q <= live_q - 1'b1;
        end
        slot_q <= slot_q + 1'b1;
      end
      if (ctrl_i.age_page_end) begin
        if (occ_q[cur_page_q] == '0) begin
          emp_q[emp_cnt_q[PageW-1:0]] <= cur_page_q;
          emp_cnt_q                   <= emp_cnt_q + 1'b1;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (ctrl_i.retire_step && r_hit) begin
        emp_rd_q      <= emp_rd_q + 1'b1;
        act_q[r_idx]  <= act_q[act_len_q[PageW-1:0] - 1'b1];
        act_len_q     <= act_len_q - 1'b1;
      end
      if (ctrl_i.accum) acc_q <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
      if (ctrl_i.place_start) begin
        found_q <= s_found;
        fpage_q <= s_page;
        fslot_q <= s_slot;
        fnew_q  <= s_new;
        if (!is_tick_q) count_q <= count_q - 1'b1;
      end
      if (ctrl_i.place_commit) begin
        occ_q[fpage_q][fslot_q] <= 1'b1;
        live_q <= live_q + 1'b1;
        if (fnew_q) begin
          act_q[act_len_q[PageW-1:0]] <= fpage_q;
          act_len_q <= act_len_q + 1'b1;
        end
        if (is_tick_q) acc_q <= acc_q - interval;
      end
      if (ctrl_i.emit_place) n_q <= n_q + 1'b1;
    end
  end

  logic spawn_more_c, tick_more_c;
  assign tick_more_c  = (n_q < 7'(MaxSpawns)) && (acc_q >= interval) && (live_q < cap);
  assign spawn_more_c = (count_q != '0);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_place) begin
      out_placed_q <= 1'b1;
      out_page_q   <= fpage_q;
      out_slot_q   <= fslot_q;
      out_live_q   <= live_q;
      out_last_q   <= is_tick_q
        ? !((n_q + 1'b1 < 7'(MaxSpawns)) && (acc_q >= interval) && (live_q < cap)
            && s_found)
        : 1'b0;
    end else if (ctrl_i.emit_empty) begin
      out_placed_q <= 1'b0;
      out_page_q   <= '0;
      out_slot_q   <= '0;
      out_live_q   <= live_q;
      out_last_q   <= 1'b1;
    end
  end

  // Spawn results mark last by lookahead: remaining placements all fail
  logic spawn_last_c;
  assign spawn_last_c = (count_q == '0) || !s_found;
  logic last_fix_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) last_fix_q <= 1'b0;
    else if (ctrl_i.emit_place) last_fix_q <= !is_tick_q && spawn_last_c;
    else if (ctrl_i.emit_empty) last_fix_q <= 1'b0;
  end

  assign stat_o.is_tick        = is_tick_q;
  assign stat_o.age_pages_done = (idx_q >= act_len_q) || (idx_q >= LenW'(PageCount));
  assign stat_o.age_slot_last  = (slot_q == SlotW'(PageSlots - 1));
  assign stat_o.retire_done    = !r_hit;
  assign stat_o.tick_can_place = tick_more_c;
  assign stat_o.spawn_more     = spawn_more_c;
  assign stat_o.place_found    = found_q;
  assign stat_o.any_emitted    = (n_q != '0);

  assign out_item_o.placed      = out_placed_q;
  assign out_item_o.page_number = out_page_q;
  assign out_item_o.slot_number = out_slot_q;
  assign out_item_o.live_count  = out_live_q;
  assign out_item_o.last        = out_last_q | last_fix_q;

endmodule

// ===== design/paged_slot_allocator_with_expiry.sv =====
// ----------------------------------------------------------------------------
// paged_slot_allocator_with_expiry
// Paged slot allocator with per-slot ages, timed expiry and spawning.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_ready_o   | psa_pkg::in_item_t
//   out     | output    | out_valid_o/out_ready_i | psa_pkg::out_item_t
//   cfg     | input     | APB, pready always high | 2 x 32-bit, 1 x 5-bit registers
//
// A tick sweeps each active page (page load, a read and a write per slot
// through the single age memory port, then page close), retires emptied
// pages and places slots; an empty result is sent when nothing is placed.
// A spawn tries one placement per requested slot, with the same empty
// result when nothing is placed. One item at a time.
// Reset clears bitmaps, list length, counters and the accumulator.
// A stalled result holds the sequencer in its emit state.
// ----------------------------------------------------------------------------
module paged_slot_allocator_with_expiry (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  psa_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output psa_pkg::out_item_t  out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import psa_pkg::*;

  logic [31:0] max_life_q, interval_q;
  logic [4:0]  pages_q;
  ctrl_t       ctrl;
  stat_t       stat;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_life_q <= 32'd1000000;
      interval_q <= 32'd10000;
      pages_q    <= 5'd16;
    end else if (wr && paddr[1:0] == 2'b00) begin
      unique case (paddr[3:2])
        RegMaxLife:  max_life_q <= pwdata;
        RegInterval: interval_q <= pwdata;
        RegPages:    pages_q    <= pwdata[4:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegMaxLife:  prdata = max_life_q;
      RegInterval: prdata = interval_q;
      RegPages:    prdata = {27'd0, pages_q};
      default:     prdata = '0;
    endcase
  end

  psa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_ready_i, .out_valid_o,
    .stat_i (stat), .ctrl_o (ctrl)
  );

  psa_datapath u_dp (
    .clk_i, .rst_ni, .in_item_i,
    .max_life_i (max_life_q), .interval_i (interval_q), .pages_i (pages_q),
    .ctrl_i (ctrl), .stat_o (stat), .out_item_o
  );

endmodule
